[src/plti_pkg.sv]
// Shared types and constants for the piecewise-linear table block.
package plti_pkg;

  localparam int unsigned MaxSamplesDef = 1024;
  localparam int unsigned MaxDimsDef    = 8;
  localparam int unsigned ResultCap     = 8;
  localparam int unsigned DataW         = 32;
  localparam int unsigned FracW         = 17;

  typedef enum logic [1:0] {
    REQ_WR_TIME  = 2'd0,
    REQ_WR_COMP  = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_RD_INDEX = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    FLAG_IN_RANGE = 2'd0,
    FLAG_LOW      = 2'd1,
    FLAG_HIGH     = 2'd2
  } flag_e;

  typedef enum logic [1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_DIMS_IN_USE  = 2'd1
  } cfg_idx_e;

  // Divider handshake between the sequencer and the fraction unit.
  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [FracW-1:0] frac;
  } div_rsp_t;

endpackage

[src/piecewise_linear_table_interp_top.sv]
// Top level: command decode, binary search sequencer, interpolation and output.
// Writes complete on acceptance and leave busy low. A query runs search steps (up to eleven
// at 1024 samples, one memory read each), closes the search, reads the bracket times, runs
// the fraction divider, then reads both values, multiplies and emits per component. Indexed
// reads and clamped queries (after their search) read one time, then read, scale and emit
// per component. One item at a time; busy is high meanwhile. Reset clears control and sets
// both registers to 1; the memories are undefined until written. Results cannot be stalled.
module piecewise_linear_table_interp_top
  import plti_pkg::*;
#(
  parameter int unsigned MaxSamples = MaxSamplesDef,
  parameter int unsigned MaxDims    = MaxDimsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [10:0] sample_index_i,
  input  logic [2:0]  component_index_i,
  input  logic [31:0] time_in_i,
  input  logic [31:0] value_in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [31:0] value_out_o,
  output logic [31:0] time_out_o,
  output logic [2:0]  component_out_o,
  output logic [1:0]  range_flag_o,
  output logic        last_item_o
);

  localparam int unsigned SampW = $clog2(MaxSamples);
  localparam int unsigned DimW  = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int unsigned CntW  = SampW + 1;
  localparam int unsigned DimsCap = (MaxDims < ResultCap) ? MaxDims : ResultCap;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SRCH   = 11'b00000000010,
    S_SWAIT  = 11'b00000000100,
    S_T0     = 11'b00000001000,
    S_T0W    = 11'b00000010000,
    S_T1W    = 11'b00000100000,
    S_DIV    = 11'b00001000000,
    S_V0     = 11'b00010000000,
    S_V1     = 11'b00100000000,
    S_MUL    = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [10:0] cnt_q, cnt_d;
  logic [3:0]  dims_q, dims_d;

  // effective registers
  logic [CntW-1:0] n_eff;
  logic [3:0]      d_eff;
  always_comb begin
    if (cnt_q == 11'd0) n_eff = CntW'(1);
    else if (32'(cnt_q) > MaxSamples) n_eff = CntW'(MaxSamples);
    else n_eff = CntW'(cnt_q);
    if (dims_q == 4'd0) d_eff = 4'd1;
    else if (32'(dims_q) > DimsCap) d_eff = 4'(DimsCap);
    else d_eff = dims_q;
  end

  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, mid;
  logic [SampW-1:0] samp_q, samp_d;   // sample read in emit (or upper neighbour)
  logic             interp_q, interp_d;
  logic [1:0]       flag_q, flag_d;
  logic signed [31:0] tq_q, tq_d, t0_q, t0_d, tout_q, tout_d;
  logic signed [31:0] v0_q, v0_d;
  logic [3:0]       comp_q, comp_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic signed [49:0] prod_q, prod_d;

  // memory ports
  logic             t_we, v_we;
  logic [SampW-1:0] t_addr, v_samp;
  logic [DimW-1:0]  v_comp;
  logic [31:0]      t_rdata, v_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  plti_store #(.MaxSamples(MaxSamples), .MaxDims(MaxDims)) u_store (
    .clk_i     (clk_i),
    .t_we_i    (t_we),
    .t_addr_i  (t_addr),
    .t_wdata_i (time_in_i),
    .t_rdata_o (t_rdata),
    .v_we_i    (v_we),
    .v_samp_i  (v_samp),
    .v_comp_i  (v_comp),
    .v_wdata_i (value_in_i),
    .v_rdata_o (v_rdata)
  );

  plti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic accept;
  logic sidx_neg, sidx_ok;
  logic signed [33:0] dd, uu;
  logic signed [32:0] vdiff;
  logic signed [31:0] res;
  logic [49:0] biased;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;
  assign sidx_neg    = sample_index_i[10];
  assign sidx_ok     = !sidx_neg && (32'(sample_index_i) < MaxSamples);
  assign mid         = CntW'((lo_q + hi_q) >> 1);

  assign vdiff  = 33'(signed'(v_rdata)) - 33'(v0_q);
  // floor((p + 32768) / 65536) as an arithmetic shift
  assign biased = 50'(prod_q + 50'sd32768);
  assign res    = 32'(v0_q + 32'(signed'(biased[49:16])));

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    dims_d   = dims_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    samp_d   = samp_q;
    interp_d = interp_q;
    flag_d   = flag_q;
    tq_d     = tq_q;
    t0_d     = t0_q;
    tout_d   = tout_q;
    v0_d     = v0_q;
    comp_d   = comp_q;
    frac_d   = frac_q;
    prod_d   = prod_q;
    t_we     = 1'b0;
    v_we     = 1'b0;
    t_addr   = sample_index_i[SampW-1:0];
    v_samp   = samp_q;
    v_comp   = DimW'(comp_q);
    div_req  = '0;
    dd       = '0;
    uu       = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SAMPLE_COUNT: cnt_d  = cfg_data_i;
        CFG_DIMS_IN_USE:  dims_d = cfg_data_i[3:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        v_samp = sample_index_i[SampW-1:0];
        v_comp = DimW'(component_index_i);
        if (accept) begin
          tq_d   = time_in_i;
          comp_d = '0;
          case (req_type_i)
            REQ_WR_TIME: t_we = sidx_ok;
            REQ_WR_COMP: v_we = sidx_ok && (32'(component_index_i) < MaxDims);
            REQ_QUERY: begin
              lo_d     = '0;
              hi_d     = n_eff;
              interp_d = 1'b1;
              state_d  = S_SRCH;
            end
            default: begin
              interp_d = 1'b0;
              // set the upper search bound nonzero so the low-clamp check stays off
              hi_d     = n_eff;
              if (sidx_neg) begin
                samp_d = '0;
                flag_d = FLAG_LOW;
              end else if (CntW'(sample_index_i) >= n_eff || sample_index_i[10:SampW] != '0) begin
                samp_d = SampW'(n_eff - CntW'(1));
                flag_d = FLAG_HIGH;
              end else begin
                samp_d = sample_index_i[SampW-1:0];
                flag_d = FLAG_IN_RANGE;
              end
              state_d = S_T0;
            end
          endcase
        end
      end
      S_SRCH: begin
        t_addr = SampW'(mid);
        if (lo_q < hi_q) state_d = S_SWAIT;
        else if (lo_q >= n_eff) begin
          samp_d   = SampW'(n_eff - CntW'(1));
          flag_d   = FLAG_HIGH;
          interp_d = 1'b0;
          state_d  = S_T0;
        end else if (lo_q == '0) begin
          samp_d   = '0;
          interp_d = 1'b0;
          state_d  = S_T0;
          flag_d   = FLAG_IN_RANGE; // resolved against time 0 on its read
        end else begin
          samp_d  = SampW'(lo_q);
          state_d = S_T0;
        end
      end
      S_SWAIT: begin
        if ($signed(t_rdata) < tq_q) lo_d = mid + CntW'(1);
        else hi_d = mid;
        state_d = S_SRCH;
      end
      S_T0: begin
        // read lower bracket (interp) or the emitted sample's time
        t_addr  = interp_q ? (samp_q - SampW'(1)) : samp_q;
        state_d = S_T0W;
      end
      S_T0W: begin
        t_addr = samp_q;
        if (interp_q) begin
          t0_d    = t_rdata;
          tout_d  = tq_q;
          state_d = S_T1W;
        end else begin
          tout_d = t_rdata;
          if (lo_q == '0 && hi_q == '0 && flag_q == FLAG_IN_RANGE && tq_q < $signed(t_rdata)
              && state_q == S_T0W && samp_q == '0 && lo_q == hi_q)
            flag_d = FLAG_LOW;
          frac_d  = '0;
          state_d = S_V1;
        end
      end
      S_T1W: begin
        dd = 34'($signed(t_rdata)) - 34'(t0_q);
        uu = 34'(tq_q) - 34'(t0_q);
        if (dd <= 0) begin
          frac_d  = FracW'(65536);
          state_d = S_V0;
        end else begin
          if (uu < 0) uu = '0;
          if (uu > dd) uu = dd;
          div_req.start = 1'b1;
          div_req.num   = uu[32:0];
          div_req.den   = dd[32:0];
          state_d       = S_DIV;
        end
        flag_d = FLAG_IN_RANGE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          frac_d  = div_rsp.frac;
          state_d = S_V0;
        end
      end
      S_V0: begin
        // issue read of lower value
        v_samp  = samp_q - SampW'(1);
        state_d = S_V1;
      end
      S_V1: begin
        // lower value arrives (interp) ; issue read of emitted/upper value
        if (interp_q) v0_d = v_rdata;
        else v0_d = '0;
        v_samp  = samp_q;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = interp_q ? 50'(vdiff) * 50'(signed'({1'b0, frac_q}))
                           : 50'(signed'(v_rdata)) <<< 16;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        comp_d = comp_q + 4'd1;
        if (comp_q + 4'd1 >= d_eff) state_d = S_IDLE;
        else state_d = interp_q ? S_V0 : S_V1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 11'd1;
      dims_q  <= 4'd1;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dims_q  <= dims_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q   <= samp_d;
    interp_q <= interp_d;
    flag_q   <= flag_d;
    tq_q     <= tq_d;
    t0_q     <= t0_d;
    tout_q   <= tout_d;
    v0_q     <= v0_d;
    comp_q   <= comp_d;
    frac_q   <= frac_d;
    prod_q   <= prod_d;
  end

  // result word is shown combinationally during the emit cycle
  assign result_valid_o  = (state_q == S_EMIT);
  assign value_out_o     = interp_q ? res : 32'(signed'(biased[49:16]));
  assign time_out_o      = tout_q;
  assign component_out_o = comp_q[2:0];
  assign range_flag_o    = flag_q;
  assign last_item_o     = (comp_q + 4'd1 == d_eff);

  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> busy)
    else $error("result shown while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> comp_q < d_eff)
    else $error("component beyond dims in use");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> hi_q <= n_eff)
    else $error("search bound past sample count");

endmodule

[src/plti_div.sv]
// Restoring divider giving floor(u * 65536 / d), one quotient bit per cycle.
module plti_div
  import plti_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned StepW = 5;
  localparam int unsigned RemW  = 34;

  logic [RemW-1:0]  rem_q, rem_d;
  logic [32:0]      den_q, den_d;
  logic [FracW-1:0] quo_q, quo_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RemW-1:0]  trial;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = RemW'(0);
    if (req_i.start) begin
      // u <= d so the quotient fits in 17 bits: start with u as remainder
      rem_d  = RemW'(req_i.num);
      den_d  = req_i.den;
      quo_d  = '0;
      step_d = StepW'(FracW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = rem_q - RemW'(den_q);
      if (step_q == StepW'(FracW)) begin
        // first step: bit 16 is u >= d
        if (!trial[RemW-1]) begin
          quo_d = {quo_q[FracW-2:0], 1'b1};
          rem_d = trial << 1;
        end else begin
          quo_d = {quo_q[FracW-2:0], 1'b0};
          rem_d = rem_q << 1;
        end
      end else if (!trial[RemW-1]) begin
        quo_d = {quo_q[FracW-2:0], 1'b1};
        rem_d = trial << 1;
      end else begin
        quo_d = {quo_q[FracW-2:0], 1'b0};
        rem_d = rem_q << 1;
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.frac = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q)
    else $error("divider failed to start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q != '0)
    else $error("divider step count ran out while busy");

endmodule

[src/plti_store.sv]
// Time and value memories, one synchronous read port each, read data registered.
module plti_store
  import plti_pkg::*;
#(
  parameter int unsigned MaxSamples = MaxSamplesDef,
  parameter int unsigned MaxDims    = MaxDimsDef,
  localparam int unsigned SampW     = $clog2(MaxSamples),
  localparam int unsigned DimW      = (MaxDims > 1) ? $clog2(MaxDims) : 1,
  localparam int unsigned ValAw     = $clog2(MaxSamples * MaxDims)
) (
  input  logic             clk_i,
  input  logic             t_we_i,
  input  logic [SampW-1:0] t_addr_i,
  input  logic [DataW-1:0] t_wdata_i,
  output logic [DataW-1:0] t_rdata_o,
  input  logic             v_we_i,
  input  logic [SampW-1:0] v_samp_i,
  input  logic [DimW-1:0]  v_comp_i,
  input  logic [DataW-1:0] v_wdata_i,
  output logic [DataW-1:0] v_rdata_o
);

  logic [DataW-1:0] time_mem  [MaxSamples];
  logic [DataW-1:0] value_mem [MaxSamples * MaxDims];
  logic [ValAw-1:0] v_addr;

  assign v_addr = ValAw'(v_samp_i) * ValAw'(MaxDims) + ValAw'(v_comp_i);

  always_ff @(posedge clk_i) begin
    if (t_we_i) begin
      time_mem[t_addr_i] <= t_wdata_i;
    end
    t_rdata_o <= time_mem[t_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (v_we_i) begin
      value_mem[v_addr] <= v_wdata_i;
    end
    v_rdata_o <= value_mem[v_addr];
  end

endmodule

[test/testbench.sv]
// Self-checking testbench for the piecewise-linear table interpolation block.
module testbench;
  import plti_pkg::*;

  localparam int unsigned Depth     = 1024;
  localparam int unsigned Dims      = 8;
  localparam int unsigned Loaded    = 6;
  localparam int unsigned CycleCap  = 600000;

  typedef struct {
    logic [31:0] value;
    logic [31:0] stamp;
    logic [2:0]  comp;
    flag_e       flag;
    logic        last;
  } answer_t;

  class table_book;
    logic [31:0] times [Depth];
    logic [31:0] vals  [Depth][Dims];
    logic [10:0] count_reg = 11'd1;
    logic [3:0]  dims_reg  = 4'd1;
    answer_t     due [$];
    int          errors;
    int          checked;

    function int used_count();
      int n;
      n = count_reg;
      if (n < 1) n = 1;
      if (n > Depth) n = Depth;
      return n;
    endfunction

    function int used_dims();
      int d;
      d = dims_reg;
      if (d < 1) d = 1;
      if (d > Dims) d = Dims;
      return d;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [10:0] data);
      if (idx == CFG_SAMPLE_COUNT) count_reg = data;
      else dims_reg = data[3:0];
    endfunction

    function void push_sample(int s, flag_e flag);
      answer_t a;
      int      d;
      d = used_dims();
      for (int c = 0; c < d; c++) begin
        a.value = vals[s][c];
        a.stamp = times[s];
        a.comp  = c[2:0];
        a.flag  = flag;
        a.last  = (c == d - 1);
        due.push_back(a);
      end
    endfunction

    // Note one accepted word and queue the results it must produce.
    function void note_item(req_e req, logic [10:0] sidx_raw, logic [2:0] comp,
                            logic [31:0] t_in, logic [31:0] v_in);
      int      sidx;
      int      n;
      int      lo;
      int      hi;
      int      mid;
      int      d;
      longint  tq;
      longint  t0;
      longint  span;
      longint  u;
      longint  f;
      longint  v0;
      longint  p;
      answer_t a;
      sidx = $signed(sidx_raw);
      n    = used_count();
      tq   = longint'($signed(t_in));
      case (req)
        REQ_WR_TIME: begin
          if (sidx >= 0) times[sidx] = t_in;
        end
        REQ_WR_COMP: begin
          if (sidx >= 0) vals[sidx][comp] = v_in;
        end
        REQ_RD_INDEX: begin
          if (sidx < 0) push_sample(0, FLAG_LOW);
          else if (sidx >= n) push_sample(n - 1, FLAG_HIGH);
          else push_sample(sidx, FLAG_IN_RANGE);
        end
        default: begin
          lo = 0;
          hi = n;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (longint'($signed(times[mid])) < tq) lo = mid + 1;
            else hi = mid;
          end
          if (lo >= n) push_sample(n - 1, FLAG_HIGH);
          else if (lo == 0)
            push_sample(0, (tq < longint'($signed(times[0]))) ? FLAG_LOW : FLAG_IN_RANGE);
          else begin
            t0   = longint'($signed(times[lo-1]));
            span = longint'($signed(times[lo])) - t0;
            u    = tq - t0;
            if (span <= 0) f = 65536;
            else begin
              if (u < 0) u = 0;
              if (u > span) u = span;
              f = (u <<< 16) / span;
            end
            d = used_dims();
            for (int c = 0; c < d; c++) begin
              v0 = longint'($signed(vals[lo-1][c]));
              p  = (longint'($signed(vals[lo][c])) - v0) * f + 32768;
              a.value = 32'(v0 + (p >>> 16));
              a.stamp = t_in;
              a.comp  = c[2:0];
              a.flag  = FLAG_IN_RANGE;
              a.last  = (c == d - 1);
              due.push_back(a);
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [31:0] value, logic [31:0] stamp, logic [2:0] comp,
                               logic [1:0] flag, logic last);
      answer_t a;
      if (due.size() == 0) begin
        $display("%0t: unexpected result value %h time %h comp %0d", $time, value, stamp,
                 comp);
        errors++;
        return;
      end
      a = due.pop_front();
      checked++;
      if (value !== a.value) begin
        $display("%0t: value_out expected %h actual %h", $time, a.value, value);
        errors++;
      end
      if (stamp !== a.stamp) begin
        $display("%0t: time_out expected %h actual %h", $time, a.stamp, stamp);
        errors++;
      end
      if (comp !== a.comp) begin
        $display("%0t: component_out expected %0d actual %0d", $time, a.comp, comp);
        errors++;
      end
      if (flag !== a.flag) begin
        $display("%0t: range_flag expected %0d actual %0d", $time, a.flag, flag);
        errors++;
      end
      if (last !== a.last) begin
        $display("%0t: last_item expected %0d actual %0d", $time, a.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = REQ_WR_TIME;
  logic [10:0] sample_index_i = '0;
  logic [2:0]  component_index_i = '0;
  logic [31:0] time_in_i = '0;
  logic [31:0] value_in_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_SAMPLE_COUNT;
  logic [10:0] cfg_data_i = 11'd1;
  logic        result_valid_o;
  logic [31:0] value_out_o;
  logic [31:0] time_out_o;
  logic [2:0]  component_out_o;
  logic [1:0]  range_flag_o;
  logic        last_item_o;

  table_book book = new();
  int        cycles;
  bit        eager;
  int        n_queries;
  int        n_reads;
  int        n_writes;

  piecewise_linear_table_interp_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      book.check_result(value_out_o, time_out_o, component_out_o, range_flag_o, last_item_o);
  end

  function automatic int pick_gap();
    int r;
    if (eager) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic send_word(req_e req, int sidx, int comp, logic [31:0] t_in,
                           logic [31:0] v_in);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    req_type_i        <= req;
    sample_index_i    <= sidx[10:0];
    component_index_i <= comp[2:0];
    time_in_i         <= t_in;
    value_in_i        <= v_in;
    do @(posedge clk_i); while (busy);
    book.note_item(req, sidx[10:0], comp[2:0], t_in, v_in);
    if (req == REQ_QUERY) n_queries++;
    else if (req == REQ_RD_INDEX) n_reads++;
    else n_writes++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (book.due.size() != 0);
    repeat (90) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[10:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    book.set_reg(idx, data[10:0]);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_query(int n);
    int s;
    int r;
    r = $urandom_range(0, 9);
    s = $urandom_range(0, n - 1);
    if (r < 6) return book.times[s] - $urandom_range(0, 3000000);
    if (r < 8) return book.times[s];
    return $urandom();
  endfunction

  task automatic random_item(int n);
    int r;
    int s;
    r = $urandom_range(0, 19);
    s = $urandom_range(0, Depth - 1);
    if (r < 11) send_word(REQ_QUERY, 0, $urandom_range(0, 7), pick_query(n), $urandom());
    else if (r < 15) send_word(REQ_RD_INDEX, $urandom_range(0, 2047), $urandom_range(0, 7),
                               $urandom(), $urandom());
    else if (r < 17) send_word(REQ_WR_COMP, s, $urandom_range(0, 7), $urandom(), $urandom());
    else if (r < 18) send_word(REQ_WR_TIME, s, $urandom_range(0, 7), $urandom(), $urandom());
    else send_word(($urandom_range(0, 1) != 0) ? REQ_WR_TIME : REQ_WR_COMP,
                   $urandom_range(1024, 2047), $urandom_range(0, 7), $urandom(), $urandom());
  endtask

  initial begin
    logic [31:0] t;
    int          counts [8];
    int          dimsv [8];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load the first slots fully; sample counts stay within them so that no
    // search or read can touch an empty entry.
    eager = 1'b1;
    t = 32'h8000_03e8;
    for (int s = 0; s < Loaded; s++) begin
      send_word(REQ_WR_TIME, s, 0, t, 0);
      for (int c = 0; c < Dims; c++)
        send_word(REQ_WR_COMP, s, c, $urandom(), $urandom());
      t = t + (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4000000));
    end
    eager = 1'b0;
    send_word(REQ_WR_COMP, 1, 0, 0, 32'h7fff_ffff);
    send_word(REQ_WR_COMP, 2, 0, 0, 32'h8000_0000);
    settle();

    write_reg(CFG_SAMPLE_COUNT, Loaded);
    write_reg(CFG_DIMS_IN_USE, 8);
    send_word(REQ_QUERY, 0, 0, 32'h8000_0000, 0);
    send_word(REQ_QUERY, 0, 0, 32'h7fff_ffff, 0);
    send_word(REQ_QUERY, 0, 0, book.times[0], 0);
    send_word(REQ_QUERY, 0, 0, book.times[Loaded-1], 0);
    send_word(REQ_QUERY, 0, 0, book.times[Loaded-1] + 1, 0);
    send_word(REQ_QUERY, 0, 0, book.times[2] - 1, 0);
    send_word(REQ_QUERY, 0, 0, book.times[3], 0);
    send_word(REQ_RD_INDEX, -1, 0, 0, 0);
    send_word(REQ_RD_INDEX, -1024, 7, 0, 0);
    send_word(REQ_RD_INDEX, 1023, 0, 0, 0);
    send_word(REQ_RD_INDEX, 0, 0, 0, 0);
    // Equal neighbouring times, then a descending pair.
    send_word(REQ_WR_TIME, 5, 0, book.times[4], 0);
    send_word(REQ_QUERY, 0, 0, book.times[4], 0);
    send_word(REQ_WR_TIME, 3, 0, book.times[2] - 500, 0);
    send_word(REQ_QUERY, 0, 0, book.times[2] - 1, 0);
    send_word(REQ_WR_TIME, -5, 0, 32'h1234_5678, 0);
    send_word(REQ_WR_COMP, -1, 3, 0, 32'hdead_beef);
    send_word(REQ_RD_INDEX, 5, 0, 0, 0);
    settle();

    // Extremes and out-of-range register values among the settings.
    counts = '{1, 2, 6, 0, 3, 5, 6, 4};
    dimsv  = '{1, 8, 0, 15, 3, 9, 8, 5};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SAMPLE_COUNT, counts[ph]);
      write_reg(CFG_DIMS_IN_USE, dimsv[ph]);
      eager = (ph == 3);
      repeat (5) random_item(book.used_count());
      settle();
    end

    $display("covered %0d queries, %0d indexed reads, %0d writes; %0d results checked",
             n_queries, n_reads, n_writes, book.checked);
    $display("sample counts 0..%0d and component counts 0..15 written in eight phases",
             Loaded);
    if (book.errors == 0 && book.due.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
